@@ hdl/sample_path_to_id_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Sample path to id parser: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PATH_TO_ID_PARSER_DEFINES_SVH
`define SAMPLE_PATH_TO_ID_PARSER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define SPTIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define SPTIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define SPTIP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/sptip_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample path to id parser package
// Phase codes, character constants and field widths.
// ----------------------------------------------------------------------------
package sptip_pkg;

    localparam int CHAR_W = 8;
    localparam int ID_W   = 16;
    localparam int ACC_W  = 9;
    localparam int PROD_W = 12;
    localparam int BANK_W = 5;
    localparam int SMP_W  = 4;
    localparam int DIG_W  = 2;

    localparam logic [ACC_W-1:0] BANK_MAX    = 9'd16;
    localparam logic [ACC_W-1:0] SAMPLE_MAX  = 9'd15;
    localparam logic [ACC_W-1:0] VARIANT_MAX = 9'd255;

    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_K     = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_B       = 4'd0,
        PH_A       = 4'd1,
        PH_N       = 4'd2,
        PH_K       = 4'd3,
        PH_BANK    = 4'd4,
        PH_SAMPLE  = 4'd5,
        PH_VARIANT = 4'd6,
        PH_W       = 4'd7,
        PH_SA      = 4'd8,
        PH_SV      = 4'd9,
        PH_DONE    = 4'd10
    } t_phase;

endpackage

@@ hdl/sample_path_to_id_parser.sv @@
// ----------------------------------------------------------------------------
// Sample path to id parser
// Checks a streamed path of the form bank<B>/<S>.<V>.wav and builds its id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one path character per item (i_char_in) plus
//   i_end_of_string on the last character. Output channel carries one
//   result item per string: o_path_valid and o_file_id, where file_id is
//   (B-1)<<12 | S<<8 | V, or zero when the string does not match.
//   Characters without the end mark produce no result item.
// Path: a string's last character passes the input register and then the
//   result register, where its result item is offered; a held result
//   register keeps that character waiting in the input register.
// Throughput: one character per cycle while o_stall stays low. The per-character state
//   update (compare, one multiply by ten done as shift-add, one bound check)
//   sits between the input register and the parse state / result registers.
// Reset (synchronous, active low): both stages empty, parse state back to
//   "expect b". The next string starts fresh.
// Stall: while the result register is held by i_stall, non-final characters
//   still advance; a final character waits in the input register, and
//   o_stall rises only then. The parse state clears after every final char.
// ----------------------------------------------------------------------------
module sample_path_to_id_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sptip_pkg::CHAR_W-1:0]  i_char_in,
    input  logic                          i_end_of_string,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_path_valid,
    output logic [sptip_pkg::ID_W-1:0]    o_file_id
);

    // Input register stage
    logic                         r_s1_valid;
    logic [sptip_pkg::CHAR_W-1:0] r_s1_char;
    logic                         r_s1_eos;

    // Parse state
    sptip_pkg::t_phase            r_phase, n_phase;
    logic [sptip_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [sptip_pkg::DIG_W-1:0]  r_digits, n_digits;
    logic                         r_lz, n_lz;
    logic [sptip_pkg::BANK_W-1:0] r_bank, n_bank;
    logic [sptip_pkg::SMP_W-1:0]  r_sample, n_sample;
    logic                         r_failed, n_failed;

    // Result register
    logic                         r_out_valid;
    logic                         r_path_valid, n_path_valid;
    logic [sptip_pkg::ID_W-1:0]   r_file_id, n_file_id;

    logic                         out_free;
    logic                         s1_fire;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic [sptip_pkg::PROD_W-1:0] acc_next;
    logic [sptip_pkg::ACC_W-1:0]  num_max;
    logic [sptip_pkg::BANK_W-1:0] bank_m1;

    // Result register can take a new item when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    // Advance a character; a final one needs room in the result register.
    assign s1_fire  = r_s1_valid && (!r_s1_eos || out_free);
    assign o_stall  = r_s1_valid && !s1_fire;

    assign is_digit = (r_s1_char >= sptip_pkg::CH_ZERO) && (r_s1_char <= sptip_pkg::CH_NINE);
    assign digit    = r_s1_char[3:0];
    // acc * 10 + d as shift-add
    assign acc_next = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                    + {{(sptip_pkg::PROD_W-4){1'b0}}, digit};

    always_comb begin
        case (r_phase)
            sptip_pkg::PH_BANK:   num_max = sptip_pkg::BANK_MAX;
            sptip_pkg::PH_SAMPLE: num_max = sptip_pkg::SAMPLE_MAX;
            default:              num_max = sptip_pkg::VARIANT_MAX;
        endcase
    end

    // Next parse state for the character in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_lz     = r_lz;
        n_bank   = r_bank;
        n_sample = r_sample;
        n_failed = r_failed;
        if (!r_failed) begin
            unique case (r_phase)
                sptip_pkg::PH_B: begin
                    if (r_s1_char == sptip_pkg::CH_B) n_phase = sptip_pkg::PH_A;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_A: begin
                    if (r_s1_char == sptip_pkg::CH_A) n_phase = sptip_pkg::PH_N;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_N: begin
                    if (r_s1_char == sptip_pkg::CH_N) n_phase = sptip_pkg::PH_K;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_K: begin
                    if (r_s1_char == sptip_pkg::CH_K) n_phase = sptip_pkg::PH_BANK;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_BANK, sptip_pkg::PH_SAMPLE, sptip_pkg::PH_VARIANT: begin
                    if (is_digit) begin
                        // fail the path on a digit after a leading zero or past the bound
                        if (r_lz) begin
                            n_failed = 1'b1;
                        end else if (acc_next > {3'b000, num_max}) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc = acc_next[sptip_pkg::ACC_W-1:0];
                            if (r_digits == 2'd0 && digit == 4'd0) n_lz = 1'b1;
                            if (r_digits != 2'd3) n_digits = r_digits + 2'd1;
                        end
                    end else if (r_digits == 2'd0) begin
                        n_failed = 1'b1;
                    end else if (r_phase == sptip_pkg::PH_BANK) begin
                        if (r_acc == '0 || r_s1_char != sptip_pkg::CH_SLASH) begin
                            n_failed = 1'b1;
                        end else begin
                            n_bank   = r_acc[sptip_pkg::BANK_W-1:0];
                            n_acc    = '0;
                            n_digits = '0;
                            n_lz     = 1'b0;
                            n_phase  = sptip_pkg::PH_SAMPLE;
                        end
                    end else if (r_phase == sptip_pkg::PH_SAMPLE) begin
                        if (r_s1_char != sptip_pkg::CH_DOT) begin
                            n_failed = 1'b1;
                        end else begin
                            n_sample = r_acc[sptip_pkg::SMP_W-1:0];
                            n_acc    = '0;
                            n_digits = '0;
                            n_lz     = 1'b0;
                            n_phase  = sptip_pkg::PH_VARIANT;
                        end
                    end else begin
                        // variant stays in the accumulator
                        if (r_s1_char != sptip_pkg::CH_DOT) n_failed = 1'b1;
                        else n_phase = sptip_pkg::PH_W;
                    end
                end
                sptip_pkg::PH_W: begin
                    if (r_s1_char == sptip_pkg::CH_W) n_phase = sptip_pkg::PH_SA;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_SA: begin
                    if (r_s1_char == sptip_pkg::CH_A) n_phase = sptip_pkg::PH_SV;
                    else n_failed = 1'b1;
                end
                sptip_pkg::PH_SV: begin
                    if (r_s1_char == sptip_pkg::CH_V) n_phase = sptip_pkg::PH_DONE;
                    else n_failed = 1'b1;
                end
                default: begin
                    // anything after ".wav", or an unused phase code
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    // Verdict and id from the state after this character.
    assign bank_m1 = n_bank - 5'd1;
    always_comb begin
        n_path_valid = !n_failed && (n_phase == sptip_pkg::PH_DONE);
        n_file_id    = '0;
        if (n_path_valid) begin
            n_file_id = {bank_m1[3:0], n_sample, n_acc[7:0]};
        end
    end

    // Input register: load when empty or when its item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_s1_char <= i_char_in;
            r_s1_eos  <= i_end_of_string;
        end
    end

    // Parse state: advance per character, clear after the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sptip_pkg::PH_B;
            r_acc    <= '0;
            r_digits <= '0;
            r_lz     <= 1'b0;
            r_bank   <= '0;
            r_sample <= '0;
            r_failed <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_eos) begin
                r_phase  <= sptip_pkg::PH_B;
                r_acc    <= '0;
                r_digits <= '0;
                r_lz     <= 1'b0;
                r_bank   <= '0;
                r_sample <= '0;
                r_failed <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_digits <= n_digits;
                r_lz     <= n_lz;
                r_bank   <= n_bank;
                r_sample <= n_sample;
                r_failed <= n_failed;
            end
        end
    end

    // Result register: hold while stalled, load on a final character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_eos) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_s1_eos) begin
            r_path_valid <= n_path_valid;
            r_file_id    <= n_file_id;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_path_valid = r_path_valid;
    assign o_file_id    = r_file_id;

endmodule

@@ hdl/sptip_checker.sv @@
// ----------------------------------------------------------------------------
// Sample path to id parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_path_to_id_parser_defines.svh"

module sptip_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_path_valid,
    input logic [sptip_pkg::ID_W-1:0]    o_file_id
);

    // a held result keeps its verdict and id
    `SPTIP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_path_valid) && $stable(o_file_id))

    // a rejected path carries a zero id
    `SPTIP_ASSERT_IMPLY(a_zero_id, i_clk, i_rst_n, o_valid && !o_path_valid, o_file_id == '0)

    // reset empties the result stage and clears o_stall
    `SPTIP_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind sample_path_to_id_parser sptip_checker u_sptip_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_path_valid (o_path_valid),
    .o_file_id    (o_file_id)
);

@@ verif/sample_path_to_id_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample path to id parser testbench
// Streams path strings one character per item into the parser and checks
// every verdict and file id against an in-bench model of the parse. Directed
// strings hit the range limits and each malformed form; random strings are
// mostly well formed with random numbers, plus corrupted ones and byte noise.
// Both channels idle and stall in random bursts, calm at the end of the run.
// ----------------------------------------------------------------------------
module sample_path_to_id_parser_tb;

    // Cycles without any accepted item before the run is called hung.
    localparam int HANG_LIMIT   = 3000;
    // Characters to stream in total, and where the calm tail begins.
    localparam int CHAR_TARGET  = 950;
    localparam int CALM_FROM    = 800;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [sptip_pkg::CHAR_W-1:0]   i_char_in;
    logic                           i_end_of_string;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_path_valid;
    logic [sptip_pkg::ID_W-1:0]     o_file_id;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parse of the current string and queues the
    // verdict each final character produces.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic                       ok;
        logic [sptip_pkg::ID_W-1:0] id;
    } t_verdict;

    class path_id_scoreboard;
        sptip_pkg::t_phase             phase;
        logic [sptip_pkg::ACC_W-1:0]   acc;
        logic [sptip_pkg::DIG_W-1:0]   digits;
        logic                          lead_zero;
        logic [sptip_pkg::BANK_W-1:0]  bank;
        logic [sptip_pkg::SMP_W-1:0]   sample;
        logic                          failed;
        t_verdict                      verdicts[$];
        int                            errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_number();
            acc       = '0;
            digits    = '0;
            lead_zero = 1'b0;
        endfunction

        function void clear_all();
            phase  = sptip_pkg::PH_B;
            clear_number();
            bank   = '0;
            sample = '0;
            failed = 1'b0;
        endfunction

        // Letter that the fixed prefix and suffix phases wait for.
        function logic [sptip_pkg::CHAR_W-1:0] letter_for(sptip_pkg::t_phase ph);
            case (ph)
                sptip_pkg::PH_B:  return sptip_pkg::CH_B;
                sptip_pkg::PH_A:  return sptip_pkg::CH_A;
                sptip_pkg::PH_N:  return sptip_pkg::CH_N;
                sptip_pkg::PH_K:  return sptip_pkg::CH_K;
                sptip_pkg::PH_W:  return sptip_pkg::CH_W;
                sptip_pkg::PH_SA: return sptip_pkg::CH_A;
                sptip_pkg::PH_SV: return sptip_pkg::CH_V;
                default:          return '0;
            endcase
        endfunction

        function void take_digit(logic [3:0] d, int unsigned limit);
            int unsigned v;
            if (lead_zero) begin
                failed = 1'b1;
                return;
            end
            v = acc * 10 + d;
            if (v > limit) begin
                failed = 1'b1;
                return;
            end
            if (digits == 0 && d == 0)
                lead_zero = 1'b1;
            acc = v[sptip_pkg::ACC_W-1:0];
            if (digits < 3)
                digits = digits + 1'b1;
        endfunction

        function void parse_char(logic [sptip_pkg::CHAR_W-1:0] c);
            logic        is_digit;
            logic [3:0]  d;
            int unsigned limit;
            is_digit = (c >= sptip_pkg::CH_ZERO) && (c <= sptip_pkg::CH_NINE);
            d        = 4'(c - sptip_pkg::CH_ZERO);
            if (phase < sptip_pkg::PH_BANK) begin
                if (c == letter_for(phase)) phase = sptip_pkg::t_phase'(phase + 4'd1);
                else failed = 1'b1;
            end else if (phase <= sptip_pkg::PH_VARIANT) begin
                limit = (phase == sptip_pkg::PH_BANK)   ? sptip_pkg::BANK_MAX :
                        (phase == sptip_pkg::PH_SAMPLE) ? sptip_pkg::SAMPLE_MAX :
                                                          sptip_pkg::VARIANT_MAX;
                if (is_digit) begin
                    take_digit(d, limit);
                end else if (digits == 0) begin
                    failed = 1'b1;
                end else if (phase == sptip_pkg::PH_BANK) begin
                    if (acc == 0 || c != sptip_pkg::CH_SLASH) begin
                        failed = 1'b1;
                    end else begin
                        bank = acc[sptip_pkg::BANK_W-1:0];
                        clear_number();
                        phase = sptip_pkg::PH_SAMPLE;
                    end
                end else if (phase == sptip_pkg::PH_SAMPLE) begin
                    if (c != sptip_pkg::CH_DOT) begin
                        failed = 1'b1;
                    end else begin
                        sample = acc[sptip_pkg::SMP_W-1:0];
                        clear_number();
                        phase = sptip_pkg::PH_VARIANT;
                    end
                end else begin
                    if (c != sptip_pkg::CH_DOT) failed = 1'b1;
                    else phase = sptip_pkg::PH_W;
                end
            end else if (phase < sptip_pkg::PH_DONE) begin
                if (c == letter_for(phase)) phase = sptip_pkg::t_phase'(phase + 4'd1);
                else failed = 1'b1;
            end else begin
                // Anything after the complete suffix, or an unused phase code.
                failed = 1'b1;
            end
        endfunction

        // Note one accepted character; a final character queues a verdict.
        function void note_char(logic [sptip_pkg::CHAR_W-1:0] c, logic eos);
            t_verdict                     v;
            logic [sptip_pkg::BANK_W-1:0] bank_m1;
            if (!failed)
                parse_char(c);
            if (!eos)
                return;
            bank_m1 = bank - 1'b1;
            v.ok = !failed && (phase == sptip_pkg::PH_DONE);
            v.id = v.ok ? {bank_m1[3:0], sample, acc[7:0]} : '0;
            verdicts.push_back(v);
            clear_all();
        endfunction

        // Compare one accepted result item with the oldest queued verdict.
        function void check_result(logic ok, logic [sptip_pkg::ID_W-1:0] id);
            t_verdict v;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result item path_valid=%0b file_id=%h",
                         $time, ok, id);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            if (ok !== v.ok) begin
                $display("%0t: path_valid mismatch: expected %0b, actual %0b",
                         $time, v.ok, ok);
                errors++;
            end
            if (id !== v.id) begin
                $display("%0t: file_id mismatch: expected %h, actual %h",
                         $time, v.id, id);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    path_id_scoreboard sb;

    // Characters of the string being built, and stimulus bookkeeping.
    logic [sptip_pkg::CHAR_W-1:0] path_chars[$];
    int                           chars_sent;
    bit                           calm;
    int                           src_calm_left;
    int                           idle_cycles;

    sample_path_to_id_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_path_valid    (o_path_valid),
        .o_file_id       (o_file_id)
    );

    // 2 ns clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge note accepted characters and check
    // accepted results. Both read pre-edge values, so no ordering race.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_char(i_char_in, i_end_of_string);
            if (o_valid && !i_stall)
                sb.check_result(o_path_valid, o_file_id);
        end
    end

    // Watchdog: count cycles in which no item moves on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, HANG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side backpressure: alternate random stall bursts with
    // calm stretches; hold stall low once the calm tail starts.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || !i_rst_n) begin
                i_stall = 1'b0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (open_left > 0) begin
                i_stall = 1'b0;
                open_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_stall    = 1'b1;
                stall_left = $urandom_range(0, 12);
            end else begin
                i_stall   = 1'b0;
                open_left = $urandom_range(0, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Send one character; maybe idle first, then hold it until accepted.
    task automatic send_char(logic [sptip_pkg::CHAR_W-1:0] c, logic eos);
        int gap;
        if (!calm) begin
            if (src_calm_left > 0) begin
                src_calm_left--;
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    gap     = $urandom_range(1, 13);
                    i_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                src_calm_left = $urandom_range(0, 30);
            end
        end
        i_valid         = 1'b1;
        i_char_in       = c;
        i_end_of_string = eos;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            path_chars.push_back(s[i]);
    endtask

    task automatic push_num(int n);
        push_text($sformatf("%0d", n));
    endtask

    // Stream the built string, end mark on its last character, then clear it.
    task automatic send_path();
        if (path_chars.size() == 0)
            path_chars.push_back(sptip_pkg::CH_B);
        for (int i = 0; i < path_chars.size(); i++)
            send_char(path_chars[i], i == path_chars.size() - 1);
        path_chars.delete();
    endtask

    // Build bank<b>/<s>.<v>.wav, optionally with a leading zero on one number.
    task automatic push_path(int b, int s, int v, int zero_at);
        push_text("bank");
        if (zero_at == 0) push_text("0");
        push_num(b);
        push_text("/");
        if (zero_at == 1) push_text("0");
        push_num(s);
        push_text(".");
        if (zero_at == 2) push_text("0");
        push_num(v);
        push_text(".wav");
    endtask

    // One random string: mostly well formed, some corrupted, some noise.
    task automatic push_random_path();
        string alphabet;
        int    kind;
        int    b;
        int    s;
        int    v;
        int    len;
        int    idx;
        alphabet = "bankwv./0123456789";
        kind     = $urandom_range(0, 99);
        if (kind < 85) begin
            // Mostly in range; now and then just past a limit.
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 16);
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 15);
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 255);
            push_path(b, s, v, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : 3);
            if (kind >= 70) begin
                // Corrupt it: replace a byte, truncate, or append extra bytes.
                idx = $urandom_range(0, path_chars.size() - 1);
                case ($urandom_range(0, 2))
                    0: path_chars[idx] = 8'($urandom_range(0, 255));
                    1: while (path_chars.size() > idx + 1) void'(path_chars.pop_back());
                    default: begin
                        len = $urandom_range(1, 3);
                        repeat (len) path_chars.push_back(alphabet[$urandom_range(0, 17)]);
                    end
                endcase
            end
        end else begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                if ($urandom_range(0, 1) == 0) path_chars.push_back(8'($urandom_range(0, 255)));
                else path_chars.push_back(alphabet[$urandom_range(0, 17)]);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb              = new();
        chars_sent      = 0;
        calm            = 1'b0;
        src_calm_left   = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_char_in       = '0;
        i_end_of_string = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: smallest and largest ids.
        push_path(1, 0, 0, 3);
        send_path();
        push_path(16, 15, 255, 3);
        send_path();
        // Each number one past its limit, and bank zero.
        push_path(17, 1, 1, 3);
        send_path();
        push_path(2, 16, 1, 3);
        send_path();
        push_path(2, 1, 256, 3);
        send_path();
        push_path(0, 1, 1, 3);
        send_path();
        // Digit after a leading zero.
        push_path(3, 4, 5, 2);
        send_path();
        // Separator with no digit before it.
        push_text("bank3/.2.wav");
        send_path();
        // Extra byte after the suffix, and a string that ends too early.
        push_text("bank3/2.5.wavv");
        send_path();
        push_text("bank3/2.5.wa");
        send_path();
        // Zero byte inside the prefix; all-ones byte as a one-character string.
        push_text("ban");
        path_chars.push_back(8'h00);
        push_text("k1/2.3.wav");
        send_path();
        path_chars.push_back(8'hFF);
        send_path();

        // Random part; calm both sides near the end.
        while (chars_sent < CHAR_TARGET) begin
            if (chars_sent >= CALM_FROM)
                calm = 1'b1;
            push_random_path();
            send_path();
        end
        i_valid = 1'b0;

        // Drain: wait until every queued verdict has been checked.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
